/* sv/drld_pkg.sv */
`default_nettype none

package drld_pkg;

  localparam int DRLD_MAX_RUNS      = 64;
  localparam int DRLD_QUEUE_DEPTH   = 2;
  localparam int DRLD_CB_W          = 22;
  localparam logic [DRLD_CB_W-1:0] DRLD_CB_RESET = 22'd4096;
  localparam logic [3:0] DRLD_MAX_FIELD = 4'd8;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_LENGTH = 2'd1,
    PH_OFFSET = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_RUN = 2'd0,
    KIND_END = 2'd1,
    KIND_ERR = 2'd2
  } kind_t;

  // one classified item from the parser to the arithmetic side
  typedef struct packed {
    kind_t       kind;
    logic        last;   // run that hits the run limit
    logic        clear;  // list restarted since the previous item
    logic [63:0] len;
    logic [63:0] off;    // already sign-extended
  } run_item_t;

endpackage

`default_nettype wire

/* sv/drld_if.sv */
`default_nettype none

interface drld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       list_start;

  modport source (output valid, output data_byte, output list_start, input ready);
  modport sink (input valid, input data_byte, input list_start, output ready);
endinterface

interface drld_out_if;
  logic               valid;
  logic               ready;
  logic [63:0]        run_length_clusters;
  logic signed [63:0] offset_delta;
  logic [63:0]        run_start_cluster;
  logic [63:0]        run_length_bytes;
  logic [63:0]        run_start_bytes;
  logic               list_end;
  logic               format_error;

  modport source (output valid, output run_length_clusters, output offset_delta,
                  output run_start_cluster, output run_length_bytes,
                  output run_start_bytes, output list_end, output format_error,
                  input ready);
  modport sink (input valid, input run_length_clusters, input offset_delta,
                input run_start_cluster, input run_length_bytes,
                input run_start_bytes, input list_end, input format_error,
                output ready);
endinterface

interface drld_cfg_if;
  logic        valid;
  logic        ready;
  logic [21:0] cluster_bytes;

  modport source (output valid, output cluster_bytes, input ready);
  modport sink (input valid, input cluster_bytes, output ready);
endinterface

`default_nettype wire

/* sv/drld_front.sv */
`default_nettype none

module drld_front #(
  parameter int MAX_RUNS = drld_pkg::DRLD_MAX_RUNS
) (
  input  logic                clk,
  input  logic                rst_n,
  drld_in_if.sink             in_bus,
  output logic                push_valid,
  output drld_pkg::run_item_t push_item,
  input  logic                push_ready
);
  import drld_pkg::*;

  localparam int CW = $clog2(MAX_RUNS + 1);

  phase_t          phase_r, phase_nxt;
  logic [3:0]      idx_r, idx_nxt;
  logic [3:0]      lsize_r, lsize_nxt;
  logic [3:0]      osize_r, osize_nxt;
  logic [63:0]     len_r, len_nxt;
  logic [63:0]     off_r, off_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            pend_r, pend_nxt;

  logic            accept;
  phase_t          ph_cur;
  logic [7:0]      b;
  logic [3:0]      hdr_ls, hdr_os;
  logic            hdr_zero, hdr_bad;
  logic [3:0]      idx_inc;
  logic [63:0]     len_fill, off_fill, off_sext;
  logic            len_done, off_done;
  logic [CW-1:0]   count_base, count_inc;
  logic            run_last;

  // a byte is taken only when the queue has room for what it may produce
  assign in_bus.ready = push_ready;
  assign accept       = in_bus.valid && push_ready;

  assign b          = in_bus.data_byte;
  assign ph_cur     = in_bus.list_start ? PH_HEADER : phase_r;
  assign hdr_ls     = b[3:0];
  assign hdr_os     = b[7:4];
  assign hdr_zero   = (b == 8'd0);
  assign hdr_bad    = (hdr_ls > DRLD_MAX_FIELD) || (hdr_os > DRLD_MAX_FIELD);
  assign idx_inc    = idx_r + 4'd1;
  assign len_done   = (idx_inc >= lsize_r);
  assign off_done   = (idx_inc >= osize_r);
  assign count_base = in_bus.list_start ? '0 : count_r;
  assign count_inc  = count_base + CW'(1);
  assign run_last   = (count_inc >= CW'(MAX_RUNS));

  // accumulators are cleared at the header, so dropping the byte into its lane equals OR
  always_comb begin
    len_fill = len_r;
    off_fill = off_r;
    len_fill[8*idx_r[2:0] +: 8] = b;
    off_fill[8*idx_r[2:0] +: 8] = b;
  end

  always_comb begin
    case (osize_r)
      4'd1:    off_sext = {{56{off_fill[7]}},  off_fill[7:0]};
      4'd2:    off_sext = {{48{off_fill[15]}}, off_fill[15:0]};
      4'd3:    off_sext = {{40{off_fill[23]}}, off_fill[23:0]};
      4'd4:    off_sext = {{32{off_fill[31]}}, off_fill[31:0]};
      4'd5:    off_sext = {{24{off_fill[39]}}, off_fill[39:0]};
      4'd6:    off_sext = {{16{off_fill[47]}}, off_fill[47:0]};
      4'd7:    off_sext = {{8{off_fill[55]}},  off_fill[55:0]};
      default: off_sext = off_fill;
    endcase
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      case (ph_cur)
        PH_HEADER: begin
          if (hdr_zero || hdr_bad) phase_nxt = PH_DONE;
          else if (hdr_ls != 4'd0) phase_nxt = PH_LENGTH;
          else                     phase_nxt = PH_OFFSET;
        end
        PH_LENGTH: begin
          if (len_done) begin
            if (osize_r != 4'd0) phase_nxt = PH_OFFSET;
            else                 phase_nxt = run_last ? PH_DONE : PH_HEADER;
          end
        end
        PH_OFFSET: begin
          if (off_done) phase_nxt = run_last ? PH_DONE : PH_HEADER;
        end
        PH_DONE:   phase_nxt = PH_DONE;
        default:   phase_nxt = PH_HEADER;
      endcase
    end
  end

  // datapath and queue writes
  always_comb begin
    idx_nxt         = idx_r;
    lsize_nxt       = lsize_r;
    osize_nxt       = osize_r;
    len_nxt         = len_r;
    off_nxt         = off_r;
    count_nxt       = count_r;
    pend_nxt        = pend_r;
    push_valid      = 1'b0;
    push_item.kind  = KIND_RUN;
    push_item.last  = 1'b0;
    push_item.clear = pend_r | in_bus.list_start;
    push_item.len   = '0;
    push_item.off   = '0;
    if (accept) begin
      pend_nxt  = pend_r | in_bus.list_start;
      count_nxt = count_base;
      case (ph_cur)
        PH_HEADER: begin
          if (hdr_zero) begin
            push_valid     = 1'b1;
            push_item.kind = KIND_END;
          end else if (hdr_bad) begin
            push_valid     = 1'b1;
            push_item.kind = KIND_ERR;
          end else begin
            lsize_nxt = hdr_ls;
            osize_nxt = hdr_os;
            len_nxt   = '0;
            off_nxt   = '0;
            idx_nxt   = '0;
          end
        end
        PH_LENGTH: begin
          len_nxt = len_fill;
          idx_nxt = len_done ? 4'd0 : idx_inc;
          if (len_done && (osize_r == 4'd0)) begin
            push_valid     = 1'b1;
            push_item.last = run_last;
            push_item.len  = len_fill;
            count_nxt      = count_inc;
          end
        end
        PH_OFFSET: begin
          off_nxt = off_fill;
          idx_nxt = off_done ? 4'd0 : idx_inc;
          if (off_done) begin
            push_valid     = 1'b1;
            push_item.last = run_last;
            push_item.len  = len_r;
            push_item.off  = off_sext;
            count_nxt      = count_inc;
          end
        end
        default: ;
      endcase
      if (push_valid) pend_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      idx_r   <= '0;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lsize_r <= lsize_nxt;
    osize_r <= osize_nxt;
    len_r   <= len_nxt;
    off_r   <= off_nxt;
  end

endmodule

`default_nettype wire

/* sv/drld_queue.sv */
`default_nettype none

module drld_queue #(
  parameter int DEPTH = drld_pkg::DRLD_QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  input  drld_pkg::run_item_t push_item,
  output logic                push_ready,
  output logic                pop_valid,
  output drld_pkg::run_item_t pop_item,
  input  logic                pop_ready
);
  import drld_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  run_item_t     mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0] fill_r, fill_nxt;
  logic          do_push, do_pop;

  assign push_ready = (fill_r != NW'(DEPTH));
  assign pop_valid  = (fill_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    if (do_push && !do_pop)      fill_nxt = fill_r + NW'(1);
    else if (do_pop && !do_push) fill_nxt = fill_r - NW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_item;
  end

endmodule

`default_nettype wire

/* sv/drld_back.sv */
`default_nettype none

module drld_back (
  input  logic                clk,
  input  logic                rst_n,
  drld_cfg_if.sink            cfg_bus,
  input  logic                pop_valid,
  input  drld_pkg::run_item_t pop_item,
  output logic                pop_ready,
  drld_out_if.source          out_bus
);
  import drld_pkg::*;

  localparam int PW = 32 + DRLD_CB_W;

  logic [DRLD_CB_W-1:0] cb_r;
  logic [63:0]          pos_r, pos_nxt, pos_base, pos_new;

  // stage 1: position update
  logic        s1_v_r, s1_v_nxt;
  logic [63:0] s1_len_r, s1_off_r, s1_start_r;
  logic        s1_end_r, s1_err_r;
  // stage 2: partial products of the byte scaling
  logic        s2_v_r, s2_v_nxt;
  logic [63:0] s2_len_r, s2_off_r, s2_start_r;
  logic        s2_end_r, s2_err_r;
  logic [PW-1:0] pl_lo_r, pl_hi_r, ps_lo_r, ps_hi_r;
  // stage 3: output register
  logic        o_v_r, o_v_nxt;

  logic adv1, adv2, adv3;
  logic is_run;

  assign cfg_bus.ready = 1'b1;

  assign adv3      = s2_v_r && (!o_v_r || out_bus.ready);
  assign adv2      = s1_v_r && (!s2_v_r || adv3);
  assign adv1      = pop_valid && (!s1_v_r || adv2);
  assign pop_ready = adv1;

  assign is_run   = (pop_item.kind == KIND_RUN);
  assign pos_base = pop_item.clear ? 64'd0 : pos_r;
  assign pos_new  = pos_base + pop_item.off;

  always_comb begin
    pos_nxt = pos_r;
    if (adv1) pos_nxt = is_run ? pos_new : pos_base;
  end

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (adv1)      s1_v_nxt = 1'b1;
    else if (adv2) s1_v_nxt = 1'b0;
    s2_v_nxt = s2_v_r;
    if (adv2)      s2_v_nxt = 1'b1;
    else if (adv3) s2_v_nxt = 1'b0;
    o_v_nxt = o_v_r;
    if (adv3)               o_v_nxt = 1'b1;
    else if (out_bus.ready) o_v_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cb_r   <= DRLD_CB_RESET;
      pos_r  <= '0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      if (cfg_bus.valid) cb_r <= cfg_bus.cluster_bytes;
      pos_r  <= pos_nxt;
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
      o_v_r  <= o_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_len_r   <= is_run ? pop_item.len : 64'd0;
      s1_off_r   <= is_run ? pop_item.off : 64'd0;
      s1_start_r <= is_run ? pos_new : 64'd0;
      s1_end_r   <= (pop_item.kind == KIND_END) || (is_run && pop_item.last);
      s1_err_r   <= (pop_item.kind == KIND_ERR);
    end
    if (adv2) begin
      s2_len_r   <= s1_len_r;
      s2_off_r   <= s1_off_r;
      s2_start_r <= s1_start_r;
      s2_end_r   <= s1_end_r;
      s2_err_r   <= s1_err_r;
      pl_lo_r    <= PW'(s1_len_r[31:0])    * PW'(cb_r);
      pl_hi_r    <= PW'(s1_len_r[63:32])   * PW'(cb_r);
      ps_lo_r    <= PW'(s1_start_r[31:0])  * PW'(cb_r);
      ps_hi_r    <= PW'(s1_start_r[63:32]) * PW'(cb_r);
    end
    if (adv3) begin
      out_bus.run_length_clusters <= s2_len_r;
      out_bus.offset_delta        <= s2_off_r;
      out_bus.run_start_cluster   <= s2_start_r;
      out_bus.run_length_bytes    <= 64'(pl_lo_r) + {pl_hi_r[31:0], 32'd0};
      out_bus.run_start_bytes     <= 64'(ps_lo_r) + {ps_hi_r[31:0], 32'd0};
      out_bus.list_end            <= s2_end_r;
      out_bus.format_error        <= s2_err_r;
    end
  end

  assign out_bus.valid = o_v_r;

endmodule

`default_nettype wire

/* sv/data_run_list_decoder.sv */
// Throughput: one list byte per cycle, sustained while results are taken.
// A run's result is registered after its last byte's beat through the queue write,
//   position add, 32x22 partial products and byte-address sum, in that order.
// in_bus.ready falls only when the 2-entry queue in front of the arithmetic is full.
// Reset (rst_n low, synchronous): parser expects a header, position and run
//   count zero, cluster size 4096, queue and pipeline empty.
`default_nettype none

module data_run_list_decoder #(
  parameter int MAX_RUNS = drld_pkg::DRLD_MAX_RUNS
) (
  input  logic       clk,
  input  logic       rst_n,
  drld_cfg_if.sink   cfg_bus,
  drld_in_if.sink    in_bus,
  drld_out_if.source out_bus
);
  import drld_pkg::*;

  logic      q_push_valid, q_push_ready;
  run_item_t q_push_item;
  logic      q_pop_valid, q_pop_ready;
  run_item_t q_pop_item;

  drld_front #(.MAX_RUNS(MAX_RUNS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .push_valid (q_push_valid),
    .push_item  (q_push_item),
    .push_ready (q_push_ready)
  );

  drld_queue #(.DEPTH(DRLD_QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_item  (q_push_item),
    .push_ready (q_push_ready),
    .pop_valid  (q_pop_valid),
    .pop_item   (q_pop_item),
    .pop_ready  (q_pop_ready)
  );

  drld_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_bus   (cfg_bus),
    .pop_valid (q_pop_valid),
    .pop_item  (q_pop_item),
    .pop_ready (q_pop_ready),
    .out_bus   (out_bus)
  );

endmodule

`default_nettype wire

/* sv/drld_checker.sv */
`default_nettype none

module drld_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_len,
  input logic [63:0] out_off,
  input logic [63:0] out_start,
  input logic [63:0] out_len_bytes,
  input logic [63:0] out_start_bytes,
  input logic        out_list_end,
  input logic        out_format_error
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_len) && $stable(out_off) &&
      $stable(out_start) && $stable(out_len_bytes) && $stable(out_start_bytes) &&
      $stable(out_list_end) && $stable(out_format_error))
    else $error("result beat changed while stalled");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_list_end && out_format_error))
    else $error("list_end and format_error together");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_format_error |-> out_len == 64'd0 && out_off == 64'd0 &&
      out_start == 64'd0 && out_len_bytes == 64'd0 && out_start_bytes == 64'd0)
    else $error("format error beat carries run data");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind data_run_list_decoder drld_checker u_drld_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_bus.valid),
  .out_ready        (out_bus.ready),
  .out_len          (out_bus.run_length_clusters),
  .out_off          (out_bus.offset_delta),
  .out_start        (out_bus.run_start_cluster),
  .out_len_bytes    (out_bus.run_length_bytes),
  .out_start_bytes  (out_bus.run_start_bytes),
  .out_list_end     (out_bus.list_end),
  .out_format_error (out_bus.format_error)
);

`default_nettype wire
